[hdl/tagc_pkg.sv]
// Package for the timed access gate controller.
// Holds state, command, lamp and picture codes, timing constants and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package tagc_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_N  = 4;
  localparam int unsigned CFG_IDX_W = $clog2(CFG_N);

  localparam logic [TIME_W-1:0] HIGH_LOCK_MS   = 16'd1500;
  localparam logic [TIME_W-1:0] HIGH_WAIT_MS   = 16'd2500;
  localparam logic [TIME_W-1:0] CHECK_FROM_MS  = 16'd1200;
  localparam logic [TIME_W-1:0] CHECK_UNTIL_MS = 16'd1220;
  localparam logic [TIME_W-1:0] AUTH_END_MS    = 16'd4000;
  localparam logic [TIME_W-1:0] TIME_MAX       = 16'hFFFF;

  localparam logic [CFG_W-1:0] BOOT_STEP_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] SCAN_RST         = 16'd3000;
  localparam logic [CFG_W-1:0] CARD_TIMEOUT_RST = 16'd30000;
  localparam logic [CFG_W-1:0] DENIED_RST       = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOOT_STEP    = 2'd0,
    REG_SCAN         = 2'd1,
    REG_CARD_TIMEOUT = 2'd2,
    REG_DENIED       = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    CMD_TICK   = 4'd0,
    CMD_BOOT   = 4'd1,
    CMD_SCAN   = 4'd2,
    CMD_LOW    = 4'd3,
    CMD_MEDIUM = 4'd4,
    CMD_HIGH   = 4'd5,
    CMD_AUTH   = 4'd6,
    CMD_DENIED = 4'd7,
    CMD_IDLE   = 4'd8,
    CMD_POLL   = 4'd9
  } cmd_e;

  typedef enum logic [3:0] {
    ST_BOOT   = 4'd0,
    ST_IDLE   = 4'd1,
    ST_SCAN   = 4'd2,
    ST_LOW    = 4'd3,
    ST_MEDIUM = 4'd4,
    ST_HIGH   = 4'd5,
    ST_WAIT   = 4'd6,
    ST_AUTH   = 4'd7,
    ST_DENIED = 4'd8
  } state_e;

  typedef enum logic [1:0] {
    LAMP_OFF   = 2'd0,
    LAMP_ON    = 2'd1,
    LAMP_BLINK = 2'd2
  } lamp_e;

  typedef enum logic [1:0] {
    VERD_NONE   = 2'd0,
    VERD_AUTH   = 2'd1,
    VERD_DENIED = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    PIC_BLANK     = 4'd0,
    PIC_HEART     = 4'd1,
    PIC_LOGO      = 4'd2,
    PIC_SHIELD    = 4'd3,
    PIC_HEARTBEAT = 4'd4,
    PIC_SCANNING  = 4'd5,
    PIC_WARNING   = 4'd6,
    PIC_CARDWAIT  = 4'd7,
    PIC_CROSS     = 4'd8,
    PIC_SAFE      = 4'd9,
    PIC_TRIANGLE  = 4'd10,
    PIC_LOCK      = 4'd11,
    PIC_OPEN      = 4'd12,
    PIC_CHECK     = 4'd13
  } pic_e;

  typedef struct packed {
    logic [3:0] command;
    logic       card_seen;
    logic       card_ok;
  } req_t;

  typedef struct packed {
    logic [3:0] state_code;
    logic [1:0] green_mode;
    logic [1:0] yellow_mode;
    logic [1:0] red_mode;
    logic       locked;
    logic [3:0] picture;
    logic [1:0] card_result;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] boot_step_ms;
    logic [CFG_W-1:0] scan_ms;
    logic [CFG_W-1:0] card_timeout_ms;
    logic [CFG_W-1:0] denied_ms;
  } cfg_t;

  typedef struct packed {
    state_e            mode;
    logic [1:0]        boot_phase;
    logic [TIME_W-1:0] time_in_mode;
    logic [TIME_W-1:0] time_in_phase;
    lamp_e             green;
    lamp_e             yellow;
    lamp_e             red;
    logic              lock_on;
    pic_e              picture;
    verdict_e          verdict;
  } ctl_t;

endpackage

[hdl/tagc_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on tagc_pkg for the payload structs.
`timescale 1ns / 1ps

interface tagc_req_if;
  logic          valid;
  logic          ready;
  tagc_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tagc_rsp_if;
  logic          valid;
  logic          ready;
  tagc_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/timed_access_gate_controller.sv]
// Top level of the timed access gate controller.
// Depends on tagc_pkg, tagc_if, tagc_cfg and tagc_core.
// Accepts one request per clock while the result side keeps up (a stalled
// result holds the request side until it is taken). Each request yields one
// result, registered in the cycle after acceptance; the controller state
// register is updated in the cycle a request is accepted, and the result
// register drains independently. Timing registers are written through a plain
// write port, only while the block is idle, a duty the block leaves to the user.
`timescale 1ns / 1ps

module timed_access_gate_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tagc_req_if.sink                         req_i,
  tagc_rsp_if.source                       rsp_o,
  input  logic                             cfg_we_i,
  input  logic [tagc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tagc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import tagc_pkg::*;

  cfg_t cfg;
  ctl_t ctl_q, ctl_d;
  rsp_t rsp_d, rsp_q;
  logic rsp_valid_q;
  logic accept;

  tagc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  tagc_core u_core (
    .cur_i (ctl_q),
    .req_i (req_i.payload),
    .cfg_i (cfg),
    .nxt_o (ctl_d),
    .rsp_o (rsp_d)
  );

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode          <= ST_BOOT;
      ctl_q.boot_phase    <= '0;
      ctl_q.time_in_mode  <= '0;
      ctl_q.time_in_phase <= '0;
      ctl_q.green         <= LAMP_OFF;
      ctl_q.yellow        <= LAMP_OFF;
      ctl_q.red           <= LAMP_OFF;
      ctl_q.lock_on       <= 1'b0;
      ctl_q.picture       <= PIC_BLANK;
      ctl_q.verdict       <= VERD_NONE;
      rsp_valid_q         <= 1'b0;
    end else begin
      if (accept) begin
        ctl_q <= ctl_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

[hdl/tagc_cfg.sv]
// Timing register bank with write-only port.
// Depends on tagc_pkg.
`timescale 1ns / 1ps

module tagc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [tagc_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [tagc_pkg::CFG_W-1:0]       wdata_i,
  output tagc_pkg::cfg_t                   cfg_o
);
  import tagc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (reg_idx_e'(idx_i))
        REG_BOOT_STEP:    cfg_d.boot_step_ms    = wdata_i;
        REG_SCAN:         cfg_d.scan_ms         = wdata_i;
        REG_CARD_TIMEOUT: cfg_d.card_timeout_ms = wdata_i;
        REG_DENIED:       cfg_d.denied_ms       = wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boot_step_ms    <= BOOT_STEP_RST;
      cfg_q.scan_ms         <= SCAN_RST;
      cfg_q.card_timeout_ms <= CARD_TIMEOUT_RST;
      cfg_q.denied_ms       <= DENIED_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/tagc_core.sv]
// Next-state logic: applies one request to the controller state.
// Depends on tagc_pkg. Purely combinational.
`timescale 1ns / 1ps

module tagc_core (
  input  tagc_pkg::ctl_t   cur_i,
  input  tagc_pkg::req_t   req_i,
  input  tagc_pkg::cfg_t   cfg_i,
  output tagc_pkg::ctl_t   nxt_o,
  output tagc_pkg::rsp_t   rsp_o
);
  import tagc_pkg::*;

  function automatic ctl_t enter(input ctl_t st, input state_e s);
    ctl_t r;
    r = st;
    r.mode = s;
    r.time_in_mode = '0;
    case (s)
      ST_BOOT: begin
        r.boot_phase = '0;
        r.time_in_phase = '0;
      end
      ST_IDLE: begin
        r.green = LAMP_OFF; r.yellow = LAMP_OFF; r.red = LAMP_OFF;
        r.lock_on = 1'b0;
        r.picture = PIC_HEARTBEAT;
      end
      ST_SCAN: begin
        r.green = LAMP_OFF; r.yellow = LAMP_OFF; r.red = LAMP_OFF;
        r.picture = PIC_SCANNING;
      end
      ST_LOW: begin
        r.green = LAMP_ON; r.yellow = LAMP_OFF; r.red = LAMP_OFF;
        r.lock_on = 1'b0;
        r.picture = PIC_SAFE;
      end
      ST_MEDIUM: begin
        r.green = LAMP_OFF; r.yellow = LAMP_ON; r.red = LAMP_OFF;
        r.lock_on = 1'b0;
        r.picture = PIC_WARNING;
      end
      ST_HIGH: begin
        r.green = LAMP_OFF; r.yellow = LAMP_OFF; r.red = LAMP_ON;
        r.lock_on = 1'b1;
        r.picture = PIC_TRIANGLE;
      end
      ST_WAIT: begin
        r.picture = PIC_CARDWAIT;
      end
      ST_AUTH: begin
        r.green = LAMP_ON; r.yellow = LAMP_OFF; r.red = LAMP_OFF;
        r.lock_on = 1'b0;
        r.picture = PIC_OPEN;
        r.verdict = VERD_AUTH;
      end
      default: begin
        r.green = LAMP_OFF; r.yellow = LAMP_OFF; r.red = LAMP_BLINK;
        r.lock_on = 1'b1;
        r.picture = PIC_CROSS;
        r.verdict = VERD_DENIED;
      end
    endcase
    return r;
  endfunction

  function automatic pic_e boot_pic(input logic [1:0] phase);
    pic_e p;
    case (phase)
      2'd0:    p = PIC_HEART;
      2'd1:    p = PIC_LOGO;
      default: p = PIC_SHIELD;
    endcase
    return p;
  endfunction

  ctl_t       nxt;
  verdict_e   result;
  logic [TIME_W-1:0] t;

  always_comb begin
    nxt    = cur_i;
    result = VERD_NONE;
    t      = (cur_i.time_in_mode == TIME_MAX) ? TIME_MAX : cur_i.time_in_mode + 16'd1;
    case (cmd_e'(req_i.command))
      CMD_TICK: begin
        nxt.time_in_mode  = t;
        nxt.time_in_phase = (cur_i.time_in_phase == TIME_MAX) ? TIME_MAX
                                                              : cur_i.time_in_phase + 16'd1;
        case (cur_i.mode)
          ST_BOOT: begin
            if (cur_i.boot_phase == 2'd3) begin
              nxt = enter(nxt, ST_IDLE);
            end else begin
              nxt.picture = boot_pic(cur_i.boot_phase);
              if (nxt.time_in_phase >= cfg_i.boot_step_ms) begin
                nxt.boot_phase    = cur_i.boot_phase + 2'd1;
                nxt.time_in_phase = '0;
              end
            end
          end
          ST_SCAN: begin
            if (t >= cfg_i.scan_ms) nxt = enter(nxt, ST_IDLE);
          end
          ST_HIGH: begin
            if (t >= HIGH_LOCK_MS) nxt.picture = PIC_LOCK;
            if (t >= HIGH_WAIT_MS) nxt = enter(nxt, ST_WAIT);
          end
          ST_WAIT: begin
            if (t >= cfg_i.card_timeout_ms) begin
              nxt = enter(nxt, ST_IDLE);
            end else if (req_i.card_seen) begin
              nxt = enter(nxt, req_i.card_ok ? ST_AUTH : ST_DENIED);
            end
          end
          ST_AUTH: begin
            if (t >= CHECK_FROM_MS && t < CHECK_UNTIL_MS) nxt.picture = PIC_CHECK;
            if (t >= AUTH_END_MS) nxt = enter(nxt, ST_IDLE);
          end
          ST_DENIED: begin
            if (t >= cfg_i.denied_ms) nxt = enter(nxt, ST_WAIT);
          end
          default: ;
        endcase
      end
      CMD_BOOT:   nxt = enter(cur_i, ST_BOOT);
      CMD_SCAN:   nxt = enter(cur_i, ST_SCAN);
      CMD_LOW:    nxt = enter(cur_i, ST_LOW);
      CMD_MEDIUM: nxt = enter(cur_i, ST_MEDIUM);
      CMD_HIGH:   nxt = enter(cur_i, ST_HIGH);
      CMD_AUTH:   nxt = enter(cur_i, ST_AUTH);
      CMD_DENIED: nxt = enter(cur_i, ST_DENIED);
      CMD_IDLE:   nxt = enter(cur_i, ST_IDLE);
      CMD_POLL: begin
        result      = cur_i.verdict;
        nxt.verdict = VERD_NONE;
      end
      default: ;
    endcase
  end

  assign nxt_o = nxt;

  always_comb begin
    rsp_o.state_code  = nxt.mode;
    rsp_o.green_mode  = nxt.green;
    rsp_o.yellow_mode = nxt.yellow;
    rsp_o.red_mode    = nxt.red;
    rsp_o.locked      = nxt.lock_on;
    rsp_o.picture     = nxt.picture;
    rsp_o.card_result = result;
  end

endmodule

[hdl/tagc_checker.sv]
// Port-level checks for the timed access gate controller, bound to the top.
// Depends on tagc_pkg and timed_access_gate_controller.
`timescale 1ns / 1ps

module tagc_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic [3:0] req_command_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [3:0] rsp_state_i,
  input logic       rsp_locked_i,
  input logic [1:0] rsp_card_result_i
);
  import tagc_pkg::*;

  logic acc, acc_poll;
  assign acc      = req_valid_i && req_ready_i;
  assign acc_poll = acc && (req_command_i == CMD_POLL);

  // every accepted request shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_valid_i)
    else $error("accepted request produced no result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_state_i) &&
                                    $stable(rsp_card_result_i))
    else $error("stalled result changed");

  a_poll_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_poll ##1 acc_poll |=> rsp_card_result_i == VERD_NONE)
    else $error("verdict not cleared by poll");

  a_nonpoll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_command_i != CMD_POLL) |=> rsp_card_result_i == VERD_NONE)
    else $error("card result on non-poll request");

  a_idle_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_command_i == CMD_IDLE) |=> rsp_state_i == ST_IDLE && !rsp_locked_i)
    else $error("idle command did not reach unlocked idle");

endmodule

bind timed_access_gate_controller tagc_props u_tagc_props (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .req_command_i     (req_i.payload.command),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_state_i       (rsp_o.payload.state_code),
  .rsp_locked_i      (rsp_o.payload.locked),
  .rsp_card_result_i (rsp_o.payload.card_result)
);
